@@ rtl/cpu_mask_priority_scheduler_assert.svh @@
// Assertion macros for the scheduler RTL.
// Depends on nothing; included by the scheduler top level to check its own logic.
`ifndef CPU_MASK_PRIORITY_SCHEDULER_ASSERT_SVH
`define CPU_MASK_PRIORITY_SCHEDULER_ASSERT_SVH
// Check that an implication holds at every clock edge outside reset.
`define CMPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Check that an implication holds in the cycle after the antecedent.
`define CMPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ rtl/cmps_pkg.sv @@
// Package for the scheduler: opcodes, status codes, constants and helpers.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package cmps_pkg;
    localparam int QueueDepth = 64;
    localparam int IdBits     = 16;
    localparam int MaskBits   = 16;
    localparam int NiceMin    = 10;
    localparam int NiceLimit  = 50;

    localparam logic [2:0] OP_PUSH   = 3'd0;
    localparam logic [2:0] OP_PEEK   = 3'd1;
    localparam logic [2:0] OP_POP    = 3'd2;
    localparam logic [2:0] OP_RUN    = 3'd3;
    localparam logic [2:0] OP_RENICE = 3'd4;
    localparam logic [2:0] OP_CLEAR  = 3'd5;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_DUP    = 3'd1;
    localparam logic [2:0] ST_INCONS = 3'd2;
    localparam logic [2:0] ST_FULL   = 3'd3;
    localparam logic [2:0] ST_NONE   = 3'd4;

    // Row-wide command sent to every cell in the same cycle.
    typedef struct packed {
        logic       remove;   // close the gap at rm_pos
        logic       insert;   // open a hole at the insert point
        logic       clear;    // drop every entry
    } t_row_cmd;

    function automatic logic [5:0] clamp_nice(input logic [5:0] n);
        if (n < 6'(NiceMin)) begin
            return 6'(NiceMin);
        end else if (n > 6'(NiceLimit - 1)) begin
            return 6'(NiceLimit - 1);
        end
        return n;
    endfunction
endpackage
`default_nettype wire

@@ rtl/cmps_if.sv @@
// Valid/ready channel interface carrying one beat of payload.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface cmps_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/cpu_mask_priority_scheduler.sv @@
// Scheduler top level: command decode, sequencer and the row of cells.
// Depends on cmps_pkg, cmps_cell and cpu_mask_priority_scheduler_assert.svh.
//
// Usage: commands arrive as beats on the input channel (op and operands);
// every command yields exactly one result beat (status and entry fields).
// The table is a row of QUEUE_DEPTH cells kept sorted by time * niceness.
// Phase one of a command searches the row in parallel and removes the
// found entry; phase two computes the new key; phase three inserts it.
// A push, run or renice that places an entry passes the key and insert
// states before its result; every other command registers its result at
// the accept. One command is in work at a time; the next is accepted at
// the edge where the result beat is taken, once the last one is through.
// A stalled output holds its beat and holds the input off until it leaves.
// Rate is set by the single search/shift row shared by the phases.
// Reset (synchronous, active low) empties the table; slot payloads are not
// cleared and are never read before being written.
`timescale 1ns / 1ps
`default_nettype none
module cpu_mask_priority_scheduler
    import cmps_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepth,
    parameter int ID_BITS     = IdBits,
    parameter int MASK_BITS   = MaskBits
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [2:0]        i_op,
    input  wire logic [ID_BITS-1:0] i_process_id,
    input  wire logic [31:0]       i_remaining_time,
    input  wire logic [5:0]        i_niceness,
    input  wire logic [MASK_BITS-1:0] i_cpu_mask,
    input  wire logic [31:0]       i_run_time,
    input  wire logic [31:0]       i_callback_answer,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [2:0]             o_status,
    output logic [ID_BITS-1:0]     o_out_id,
    output logic [31:0]            o_out_time,
    output logic [5:0]             o_out_niceness,
    output logic [MASK_BITS-1:0]   o_out_mask
);
`include "cpu_mask_priority_scheduler_assert.svh"
    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_KEY  = 2'd1;
    localparam logic [1:0] S_INS  = 2'd2;

    logic [1:0]  r_state, n_state;
    logic [CW-1:0] r_count;
    logic        r_out_valid;
    logic [2:0]  r_status;
    logic [ID_BITS-1:0] r_oid;
    logic [31:0] r_otime;
    logic [5:0]  r_onice;
    logic [MASK_BITS-1:0] r_omask;

    // Entry pending insertion.
    logic [ID_BITS-1:0]   r_pid;
    logic [31:0]          r_ptime;
    logic [5:0]           r_pnice;
    logic [MASK_BITS-1:0] r_pmask;
    logic [37:0]          r_pkey;
    logic [5:0]           r_pbits;

    logic [ID_BITS-1:0]   c_id   [QUEUE_DEPTH];
    logic [31:0]          c_time [QUEUE_DEPTH];
    logic [5:0]           c_nice [QUEUE_DEPTH];
    logic [MASK_BITS-1:0] c_mask [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] c_after, live, id_hit, mask_hit;
    logic [QUEUE_DEPTH-1:0] shift_up, shift_dn, load;

    logic        acc;
    logic [5:0]  nice_c;
    t_row_cmd    cmd;
    logic        do_rm, do_ins;
    logic [PW-1:0] rm_pos, ins_pos;
    logic        id_found, m_found;
    logic [PW-1:0] id_pos, m_pos;
    logic [32:0] run_sum;
    logic [31:0] new_time;
    logic        full;

    assign o_ready = (r_state == S_IDLE) && (!r_out_valid || i_ready);
    assign acc     = i_valid && o_ready;
    assign nice_c  = clamp_nice(i_niceness);
    assign full    = (r_count == CW'(QUEUE_DEPTH));

    // Per-cell hit vectors.
    always_comb begin
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            live[k]     = CW'(k) < r_count;
            id_hit[k]   = live[k] && (c_id[k] == i_process_id);
            mask_hit[k] = live[k] && ((c_mask[k] & i_cpu_mask) != '0);
        end
    end

    // Priority encode the first hits.
    always_comb begin
        id_found = 1'b0;
        m_found  = 1'b0;
        id_pos   = '0;
        m_pos    = '0;
        for (int k = QUEUE_DEPTH - 1; k >= 0; k--) begin
            if (id_hit[k]) begin
                id_found = 1'b1;
                id_pos   = PW'(k);
            end
            if (mask_hit[k]) begin
                m_found = 1'b1;
                m_pos   = PW'(k);
            end
        end
    end

    // Insert point: first live cell that sorts after the new entry.
    always_comb begin
        ins_pos = PW'(r_count);
        for (int k = QUEUE_DEPTH - 1; k >= 0; k--) begin
            if (live[k] && c_after[k]) begin
                ins_pos = PW'(k);
            end
        end
    end

    assign run_sum  = {1'b0, i_callback_answer} +
                      ((i_run_time <= c_time[m_pos]) ? {1'b0, c_time[m_pos] - i_run_time} : 33'd0);
    assign new_time = run_sum[32] ? '1 : run_sum[31:0];

    // Decode the row command for this cycle.
    always_comb begin
        do_rm  = 1'b0;
        rm_pos = '0;
        do_ins = (r_state == S_INS);
        if (acc) begin
            case (i_op)
                OP_POP, OP_RUN: begin
                    do_rm  = m_found;
                    rm_pos = m_pos;
                end
                OP_RENICE: begin
                    do_rm  = id_found;
                    rm_pos = id_pos;
                end
                default: begin
                    do_rm = 1'b0;
                end
            endcase
        end
        cmd.remove = do_rm;
        cmd.insert = do_ins;
        cmd.clear  = acc && (i_op == OP_CLEAR);
    end

    // Shift enables for every cell.
    always_comb begin
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            shift_up[k] = cmd.remove && (PW'(k) >= rm_pos) && (k < QUEUE_DEPTH - 1);
            shift_dn[k] = cmd.insert && (PW'(k) > ins_pos);
            load[k]     = cmd.insert && (PW'(k) == ins_pos);
        end
    end

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        localparam int UP = (g == 0) ? 0 : g - 1;
        localparam int DN = (g == QUEUE_DEPTH - 1) ? g : g + 1;
        cmps_cell #(.ID_W(ID_BITS), .MASK_W(MASK_BITS)) u_cell (
            .i_clk(i_clk),
            .i_shift_up(shift_up[g]), .i_shift_dn(shift_dn[g]), .i_load(load[g]),
            .i_new_id(r_pid), .i_new_time(r_ptime), .i_new_nice(r_pnice),
            .i_new_mask(r_pmask), .i_new_key(r_pkey), .i_new_bits(r_pbits),
            .i_up_id(c_id[UP]), .i_up_time(c_time[UP]), .i_up_nice(c_nice[UP]),
            .i_up_mask(c_mask[UP]),
            .i_dn_id(c_id[DN]), .i_dn_time(c_time[DN]), .i_dn_nice(c_nice[DN]),
            .i_dn_mask(c_mask[DN]),
            .o_id(c_id[g]), .o_time(c_time[g]), .o_nice(c_nice[g]), .o_mask(c_mask[g]),
            .o_after(c_after[g])
        );
    end

    // Capture the entry to insert and its key.
    always_ff @(posedge i_clk) begin
        if (acc) begin
            case (i_op)
                OP_PUSH: begin
                    r_pid   <= i_process_id;
                    r_ptime <= i_remaining_time;
                    r_pnice <= nice_c;
                    r_pmask <= i_cpu_mask;
                end
                OP_RUN: begin
                    r_pid   <= c_id[m_pos];
                    r_ptime <= new_time;
                    r_pnice <= c_nice[m_pos];
                    r_pmask <= c_mask[m_pos];
                end
                OP_RENICE: begin
                    r_pid   <= i_process_id;
                    r_ptime <= c_time[id_pos];
                    r_pnice <= nice_c;
                    r_pmask <= c_mask[id_pos];
                end
                default: begin
                    r_pid <= r_pid;
                end
            endcase
        end
        if (r_state == S_KEY) begin
            r_pkey  <= 38'(r_ptime) * 38'(r_pnice);
            r_pbits <= 6'($countones(r_pmask));
        end
    end

    // Sequencer, count and result register.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    case (i_op)
                        OP_PUSH:   n_state = (!id_found && !full) ? S_KEY : S_IDLE;
                        OP_RUN:    n_state = (m_found && i_callback_answer != '0) ? S_KEY
                                                                               : S_IDLE;
                        OP_RENICE: n_state = id_found ? S_KEY : S_IDLE;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_KEY:   n_state = S_INS;
            S_INS:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cmd.clear) begin
                r_count <= '0;
            end else if (cmd.remove) begin
                r_count <= r_count - CW'(1);
            end else if (cmd.insert) begin
                r_count <= r_count + CW'(1);
            end
            if (acc && n_state == S_IDLE) begin
                r_out_valid <= 1'b1;
            end else if (r_state == S_INS) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Form the result beat.
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_status <= ST_NONE;
            r_oid    <= '0;
            r_otime  <= '0;
            r_onice  <= '0;
            r_omask  <= '0;
            case (i_op)
                OP_PUSH: begin
                    if (id_found) begin
                        r_status <= (c_time[id_pos] == i_remaining_time &&
                                     c_nice[id_pos] == nice_c &&
                                     c_mask[id_pos] == i_cpu_mask) ? ST_DUP : ST_INCONS;
                    end else begin
                        r_status <= full ? ST_FULL : ST_OK;
                    end
                end
                OP_PEEK, OP_POP: begin
                    if (m_found) begin
                        r_status <= ST_OK;
                        r_oid    <= c_id[m_pos];
                        r_otime  <= c_time[m_pos];
                        r_onice  <= c_nice[m_pos];
                        r_omask  <= c_mask[m_pos];
                    end
                end
                OP_RUN: begin
                    if (m_found) begin
                        r_status <= ST_OK;
                        r_oid    <= c_id[m_pos];
                        r_otime  <= (i_callback_answer != '0) ? new_time : '0;
                        r_onice  <= c_nice[m_pos];
                        r_omask  <= c_mask[m_pos];
                    end
                end
                OP_RENICE: begin
                    if (id_found) begin
                        r_status <= ST_OK;
                        r_oid    <= i_process_id;
                        r_otime  <= c_time[id_pos];
                        r_onice  <= nice_c;
                        r_omask  <= c_mask[id_pos];
                    end
                end
                OP_CLEAR: r_status <= ST_OK;
                default:  r_status <= ST_NONE;
            endcase
        end
    end

    assign o_valid        = r_out_valid && (r_state == S_IDLE);
    assign o_status       = r_status;
    assign o_out_id       = r_oid;
    assign o_out_time     = r_otime;
    assign o_out_niceness = r_onice;
    assign o_out_mask     = r_omask;

    `CMPS_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(QUEUE_DEPTH))
    `CMPS_ASSERT_IMP(a_no_ins_full, i_clk, i_rst_n, cmd.insert, !full)
    `CMPS_ASSERT_NEXT(a_key_then_ins, i_clk, i_rst_n, r_state == S_KEY, r_state == S_INS)
    `CMPS_ASSERT_IMP(a_one_op, i_clk, i_rst_n, 1'b1, $countones({cmd.remove, cmd.insert}) <= 1)
endmodule
`default_nettype wire

@@ rtl/cmps_cell.sv @@
// One slot of the sorted row: holds an entry, compares it, and shifts.
// Depends on cmps_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cmps_cell
    import cmps_pkg::*;
#(
    parameter int ID_W   = IdBits,
    parameter int MASK_W = MaskBits
) (
    input  wire logic              i_clk,
    input  wire logic              i_shift_up,   // take from the cell below
    input  wire logic              i_shift_dn,   // take from the cell above
    input  wire logic              i_load,       // take the new entry
    input  wire logic [ID_W-1:0]   i_new_id,
    input  wire logic [31:0]       i_new_time,
    input  wire logic [5:0]        i_new_nice,
    input  wire logic [MASK_W-1:0] i_new_mask,
    input  wire logic [37:0]       i_new_key,
    input  wire logic [5:0]        i_new_bits,
    input  wire logic [ID_W-1:0]   i_up_id,
    input  wire logic [31:0]       i_up_time,
    input  wire logic [5:0]        i_up_nice,
    input  wire logic [MASK_W-1:0] i_up_mask,
    input  wire logic [ID_W-1:0]   i_dn_id,
    input  wire logic [31:0]       i_dn_time,
    input  wire logic [5:0]        i_dn_nice,
    input  wire logic [MASK_W-1:0] i_dn_mask,
    output logic [ID_W-1:0]        o_id,
    output logic [31:0]            o_time,
    output logic [5:0]             o_nice,
    output logic [MASK_W-1:0]      o_mask,
    output logic                   o_after       // new entry goes at or above here
);
    logic [ID_W-1:0]   r_id;
    logic [31:0]       r_time;
    logic [5:0]        r_nice;
    logic [MASK_W-1:0] r_mask;
    logic [37:0]       r_key;
    logic [5:0]        r_bits;

    // Compare stored key against the new entry's key.
    assign o_after = (r_key > i_new_key) || ((r_key == i_new_key) && (r_bits >= i_new_bits));

    // Shift, load or hold the payload.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_id   <= i_new_id;
            r_time <= i_new_time;
            r_nice <= i_new_nice;
            r_mask <= i_new_mask;
            r_key  <= i_new_key;
            r_bits <= i_new_bits;
        end else if (i_shift_up) begin
            r_id   <= i_dn_id;
            r_time <= i_dn_time;
            r_nice <= i_dn_nice;
            r_mask <= i_dn_mask;
            r_key  <= 38'(i_dn_time) * 38'(i_dn_nice);
            r_bits <= 6'($countones(i_dn_mask));
        end else if (i_shift_dn) begin
            r_id   <= i_up_id;
            r_time <= i_up_time;
            r_nice <= i_up_nice;
            r_mask <= i_up_mask;
            r_key  <= 38'(i_up_time) * 38'(i_up_nice);
            r_bits <= 6'($countones(i_up_mask));
        end
    end

    assign o_id   = r_id;
    assign o_time = r_time;
    assign o_nice = r_nice;
    assign o_mask = r_mask;
endmodule
`default_nettype wire

@@ tb/tb_cpu_mask_priority_scheduler.sv @@
// Testbench for cpu_mask_priority_scheduler: directed and random commands checked
// against a sorted-table predictor. Depends on cmps_pkg, cmps_if and the scheduler RTL.
`timescale 1ns / 1ps
module tb_cpu_mask_priority_scheduler;
    import cmps_pkg::*;

    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;
    localparam int         TBL_DEPTH   = 64;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] pid;
        logic [31:0] rtime;
        logic [5:0]  nice;
        logic [15:0] mask;
        logic [31:0] run;
        logic [31:0] ans;
    } t_sched_cmd;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] id;
        logic [31:0] tm;
        logic [5:0]  nice;
        logic [15:0] mask;
    } t_sched_resp;

    logic i_clk;
    logic i_rst_n;

    cmps_if #(.T(t_sched_cmd))  cmd_ch ();
    cmps_if #(.T(t_sched_resp)) rsp_ch ();

    logic [2:0]  o_status;
    logic [15:0] o_out_id;
    logic [31:0] o_out_time;
    logic [5:0]  o_out_niceness;
    logic [15:0] o_out_mask;

    cpu_mask_priority_scheduler i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (cmd_ch.valid),
        .o_ready           (cmd_ch.ready),
        .i_op              (cmd_ch.data.op),
        .i_process_id      (cmd_ch.data.pid),
        .i_remaining_time  (cmd_ch.data.rtime),
        .i_niceness        (cmd_ch.data.nice),
        .i_cpu_mask        (cmd_ch.data.mask),
        .i_run_time        (cmd_ch.data.run),
        .i_callback_answer (cmd_ch.data.ans),
        .o_valid           (rsp_ch.valid),
        .i_ready           (rsp_ch.ready),
        .o_status          (o_status),
        .o_out_id          (o_out_id),
        .o_out_time        (o_out_time),
        .o_out_niceness    (o_out_niceness),
        .o_out_mask        (o_out_mask)
    );

    assign rsp_ch.data = {o_status, o_out_id, o_out_time, o_out_niceness, o_out_mask};

    // Shadow of the sorted process table
    logic [15:0] tbl_id   [TBL_DEPTH];
    logic [31:0] tbl_time [TBL_DEPTH];
    logic [5:0]  tbl_nice [TBL_DEPTH];
    logic [15:0] tbl_mask [TBL_DEPTH];
    int          tbl_count;

    t_sched_resp pending_resp_q[$];
    int          errors;
    int          beats_sent;
    int          beats_checked;
    int          send_idle_pct;
    int          rsp_stall_pct;
    int          hold_cycles;

    // Clock and limit
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("timeout at %0t", $time);
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [5:0] sat_nice(logic [5:0] n);
        if (n < 6'd10) return 6'd10;
        if (n > 6'd49) return 6'd49;
        return n;
    endfunction

    function automatic int find_pid(logic [15:0] id);
        for (int i = 0; i < tbl_count; i++) if (tbl_id[i] == id) return i;
        return -1;
    endfunction

    function automatic int find_cpu(logic [15:0] req);
        for (int i = 0; i < tbl_count; i++) if ((tbl_mask[i] & req) != 0) return i;
        return -1;
    endfunction

    function automatic void tbl_drop(int p);
        for (int i = p; i + 1 < tbl_count; i++) begin
            tbl_id[i]   = tbl_id[i+1];
            tbl_time[i] = tbl_time[i+1];
            tbl_nice[i] = tbl_nice[i+1];
            tbl_mask[i] = tbl_mask[i+1];
        end
        tbl_count--;
    endfunction

    // Insert ahead of the first entry with a larger key or an equal key and at least as many mask bits
    function automatic void tbl_insert(logic [15:0] id, logic [31:0] t, logic [5:0] n,
                                       logic [15:0] m);
        logic [63:0] key;
        logic [63:0] k;
        int          pos;
        key = 64'(t) * 64'(n);
        for (pos = 0; pos < tbl_count; pos++) begin
            k = 64'(tbl_time[pos]) * 64'(tbl_nice[pos]);
            if (k > key || (k == key && $countones(tbl_mask[pos]) >= $countones(m))) break;
        end
        for (int i = tbl_count; i > pos; i--) begin
            tbl_id[i]   = tbl_id[i-1];
            tbl_time[i] = tbl_time[i-1];
            tbl_nice[i] = tbl_nice[i-1];
            tbl_mask[i] = tbl_mask[i-1];
        end
        tbl_id[pos] = id; tbl_time[pos] = t; tbl_nice[pos] = n; tbl_mask[pos] = m;
        tbl_count++;
    endfunction

    function automatic t_sched_resp schedule_outcome(t_sched_cmd c);
        t_sched_resp r;
        logic [5:0]  n;
        logic [32:0] nt;
        logic [31:0] rem;
        int          p;
        r = '0;
        r.status = ST_NONE;
        n = sat_nice(c.nice);
        case (c.op)
            OP_PUSH: begin
                p = find_pid(c.pid);
                if (p >= 0) begin
                    r.status = (tbl_time[p] == c.rtime && tbl_nice[p] == n &&
                                tbl_mask[p] == c.mask) ? ST_DUP : ST_INCONS;
                end else if (tbl_count >= TBL_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    tbl_insert(c.pid, c.rtime, n, c.mask);
                    r.status = ST_OK;
                end
            end
            OP_PEEK, OP_POP: begin
                p = find_cpu(c.mask);
                if (p >= 0) begin
                    r = '{ST_OK, tbl_id[p], tbl_time[p], tbl_nice[p], tbl_mask[p]};
                    if (c.op == OP_POP) tbl_drop(p);
                end
            end
            OP_RUN: begin
                p = find_cpu(c.mask);
                if (p >= 0) begin
                    r = '{ST_OK, tbl_id[p], 32'd0, tbl_nice[p], tbl_mask[p]};
                    rem = tbl_time[p];
                    tbl_drop(p);
                    if (c.ans != 0) begin
                        nt = {1'b0, c.ans};
                        if (c.run <= rem) nt = nt + 33'(rem - c.run);
                        if (nt[32]) nt = {1'b0, 32'hFFFF_FFFF};
                        tbl_insert(r.id, nt[31:0], r.nice, r.mask);
                        r.tm = nt[31:0];
                    end
                end
            end
            OP_RENICE: begin
                p = find_pid(c.pid);
                if (p >= 0) begin
                    r = '{ST_OK, c.pid, tbl_time[p], n, tbl_mask[p]};
                    tbl_drop(p);
                    tbl_insert(c.pid, r.tm, n, r.mask);
                end
            end
            OP_CLEAR: begin
                tbl_count = 0;
                r.status = ST_OK;
            end
            default: ;
        endcase
        return r;
    endfunction

    // Offer one beat, predict on acceptance, then idle at random (called at a falling edge)
    task automatic send_cmd(t_sched_cmd c);
        cmd_ch.data  = c;
        cmd_ch.valid = 1'b1;
        do @(posedge i_clk); while (!cmd_ch.ready);
        pending_resp_q.push_back(schedule_outcome(c));
        beats_sent++;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_ch.valid = 1'b0;
            @(negedge i_clk);
        end
    endtask

    function automatic t_sched_cmd mk(logic [2:0] op, logic [15:0] id, logic [31:0] t,
                                      logic [5:0] n, logic [15:0] m, logic [31:0] run,
                                      logic [31:0] ans);
        return '{op, id, t, n, m, run, ans};
    endfunction

    task automatic drain_results();
        cmd_ch.valid = 1'b0;
        wait (pending_resp_q.size() == 0);
        repeat (8) @(negedge i_clk);
    endtask

    // Receiver: random stalls plus a counted hold-off
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                rsp_ch.ready = 1'b0;
                hold_cycles--;
            end else begin
                rsp_ch.ready = ($urandom_range(99) >= rsp_stall_pct);
            end
        end
    end

    // Compare each result beat with the oldest prediction
    always @(posedge i_clk) begin
        t_sched_resp e;
        t_sched_resp a;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            a = rsp_ch.data;
            if (pending_resp_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat %h", $time, a);
            end else begin
                e = pending_resp_q.pop_front();
                beats_checked++;
                if (a.status !== e.status) begin
                    errors++;
                    $display("%0t: status exp %0d got %0d", $time, e.status, a.status);
                end
                if (a.id !== e.id) begin
                    errors++;
                    $display("%0t: id exp %h got %h", $time, e.id, a.id);
                end
                if (a.tm !== e.tm) begin
                    errors++;
                    $display("%0t: time exp %h got %h", $time, e.tm, a.tm);
                end
                if (a.nice !== e.nice) begin
                    errors++;
                    $display("%0t: niceness exp %0d got %0d", $time, e.nice, a.nice);
                end
                if (a.mask !== e.mask) begin
                    errors++;
                    $display("%0t: mask exp %h got %h", $time, e.mask, a.mask);
                end
            end
        end
    end

    // Extremes, every op and each corner case
    task automatic test_directed();
        send_cmd(mk(OP_PEEK, 16'd0, 32'd0, 6'd0, 16'hFFFF, 32'd0, 32'd0));
        send_cmd(mk(OP_PUSH, 16'hFFFF, 32'hFFFF_FFFF, 6'd63, 16'hFFFF, 32'd0, 32'd0));
        send_cmd(mk(OP_PUSH, 16'd0, 32'd0, 6'd0, 16'h0001, 32'd0, 32'd0));
        send_cmd(mk(OP_PUSH, 16'd1, 32'd5, 6'd10, 16'h00F0, 32'd0, 32'd0));
        send_cmd(mk(OP_PUSH, 16'd2, 32'd5, 6'd10, 16'h0030, 32'd0, 32'd0));
        send_cmd(mk(OP_PUSH, 16'd3, 32'd5, 6'd10, 16'h0030, 32'd0, 32'd0));
        send_cmd(mk(OP_PUSH, 16'd1, 32'd5, 6'd10, 16'h00F0, 32'd0, 32'd0));
        send_cmd(mk(OP_PUSH, 16'd1, 32'd6, 6'd10, 16'h00F0, 32'd0, 32'd0));
        send_cmd(mk(OP_PUSH, 16'd0, 32'd0, 6'd5, 16'h0001, 32'd0, 32'd0));
        send_cmd(mk(OP_PEEK, 16'd0, 32'd0, 6'd0, 16'h0000, 32'd0, 32'd0));
        send_cmd(mk(OP_PEEK, 16'd0, 32'd0, 6'd0, 16'h0010, 32'd0, 32'd0));
        send_cmd(mk(OP_RUN, 16'd0, 32'd0, 6'd0, 16'h0020, 32'd2, 32'd7));
        send_cmd(mk(OP_RUN, 16'd0, 32'd0, 6'd0, 16'h0040, 32'd100, 32'd3));
        send_cmd(mk(OP_RUN, 16'd0, 32'd0, 6'h3F, 16'h8000, 32'd0, 32'hFFFF_FFFF));
        send_cmd(mk(OP_RUN, 16'd0, 32'd0, 6'd0, 16'h0001, 32'd0, 32'd0));
        send_cmd(mk(OP_RUN, 16'd0, 32'd0, 6'd0, 16'h0100, 32'd0, 32'd1));
        send_cmd(mk(OP_RENICE, 16'd2, 32'd0, 6'd0, 16'd0, 32'd0, 32'd0));
        send_cmd(mk(OP_RENICE, 16'd3, 32'd0, 6'd63, 16'd0, 32'd0, 32'd0));
        send_cmd(mk(OP_RENICE, 16'd999, 32'd0, 6'd20, 16'd0, 32'd0, 32'd0));
        send_cmd(mk(OP_POP, 16'd0, 32'd0, 6'd0, 16'hFFFF, 32'd0, 32'd0));
        send_cmd(mk(OP_SPARE_LO, 16'hFFFF, 32'hFFFF_FFFF, 6'h3F, 16'hFFFF, '1, '1));
        send_cmd(mk(OP_SPARE_HI, 16'd0, 32'd0, 6'd0, 16'd0, 32'd0, 32'd0));
        send_cmd(mk(OP_CLEAR, 16'd0, 32'd0, 6'd0, 16'd0, 32'd0, 32'd0));
        send_cmd(mk(OP_POP, 16'd0, 32'd0, 6'd0, 16'hFFFF, 32'd0, 32'd0));
    endtask

    // Fill the table, then push past full with a new id and with a known one
    task automatic test_full_table();
        for (int i = 0; i < TBL_DEPTH + 1; i++) begin
            send_cmd(mk(OP_PUSH, 16'(i + 100), 32'($urandom_range(0, 40)),
                        6'($urandom_range(10, 49)), 16'($urandom), 32'd0, 32'd0));
        end
        send_cmd(mk(OP_PUSH, 16'd100, 32'd0, 6'd10, 16'd0, 32'd0, 32'd0));
        send_cmd(mk(OP_CLEAR, 16'd0, 32'd0, 6'd0, 16'd0, 32'd0, 32'd0));
    endtask

    // Hold the receiver off long enough that the block stalls its input
    task automatic test_output_stall();
        hold_cycles = 300;
        for (int i = 0; i < 12; i++) begin
            send_cmd(mk(OP_PUSH, 16'(i + 500), $urandom, 6'($urandom), 16'($urandom),
                        32'd0, 32'd0));
        end
        drain_results();
    endtask

    task automatic test_random(int count, int sidle, int rstall);
        t_sched_cmd c;
        int         sel;
        send_idle_pct = sidle;
        rsp_stall_pct = rstall;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(99);
            c.op    = sel < 38 ? OP_PUSH : sel < 48 ? OP_PEEK : sel < 62 ? OP_POP :
                      sel < 84 ? OP_RUN : sel < 95 ? OP_RENICE : sel < 97 ? OP_CLEAR :
                      3'($urandom_range(6, 7));
            c.pid   = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 90));
            c.rtime = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(0, 12));
            c.nice  = ($urandom_range(5) == 0) ? 6'($urandom) : 6'($urandom_range(10, 12));
            c.mask  = ($urandom_range(3) == 0) ? 16'($urandom) : 16'(1 << $urandom_range(15));
            c.run   = ($urandom_range(1) == 0) ? $urandom : 32'($urandom_range(0, 15));
            c.ans   = ($urandom_range(4) == 0) ? 32'd0 :
                      ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(1, 15));
            send_cmd(c);
        end
        drain_results();
    endtask

    initial begin
        errors        = 0;
        beats_sent    = 0;
        beats_checked = 0;
        tbl_count     = 0;
        hold_cycles   = 0;
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        cmd_ch.valid  = 1'b0;
        cmd_ch.data   = '0;
        i_rst_n       = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed();
        drain_results();
        test_full_table();
        drain_results();
        test_output_stall();
        test_random(500, 0, 0);
        test_random(500, 84, 0);
        test_random(500, 0, 84);
        test_random(500, 6, 6);

        $display("Covered %0d commands, %0d results checked: all ops, table full,",
                 beats_sent, beats_checked);
        $display("ties, saturation, output hold-off and four idle/stall mixes.");
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

@@ files.f @@
+incdir+rtl
rtl/cmps_pkg.sv
rtl/cmps_if.sv
rtl/cmps_cell.sv
rtl/cpu_mask_priority_scheduler.sv
tb/tb_cpu_mask_priority_scheduler.sv
